// ----- design/tree_common_ancestor_query_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the common ancestor query block
// Short forms for clocked assertions with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef TREE_COMMON_ANCESTOR_QUERY_ASSERT_SVH
`define TREE_COMMON_ANCESTOR_QUERY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCAQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcaq assertion failed");

// Next-cycle implication, checked outside reset.
`define TCAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcaq assertion failed");

`endif

// ----- design/tcaq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcaq_pkg
// Shared types and constants of the common ancestor query block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcaq_pkg;

	localparam int NODE_W        = 10;
	localparam int CNT_W         = 11;
	localparam int STATUS_W      = 2;
	localparam int DEF_MAX_NODES = 1024;

	localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 11'd1;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FOUND        = 2'd0,
		STATUS_ANCESTOR     = 2'd1,
		STATUS_NOT_IN_TABLE = 2'd2
	} status_t;

	// Item kinds decided at the front
	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,  // load inside the tables
		KIND_DROP   = 2'd1,  // load beyond the tables
		KIND_QUERY  = 2'd2,  // query with both nodes in range
		KIND_REJECT = 2'd3   // query with a node out of range
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LIFT_X,
		BK_LIFT_Y,
		BK_MEET,
		BK_DONE
	} bk_state_t;

	// Queue item: a/b/c carry node/parent/depth for loads, x/y for queries
	typedef struct packed {
		kind_t             kind;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [NODE_W-1:0] c;
	} qitem_t;

	// Queue head as seen by the back part
	typedef struct packed {
		logic   valid;
		qitem_t item;
	} qhead_t;

	typedef struct packed {
		logic [NODE_W-1:0] parent;
		logic [NODE_W-1:0] depth;
	} entry_t;

endpackage

`default_nettype wire

// ----- design/tree_common_ancestor_query.sv -----
// A load waits in the queue and is written to the node table as the idle back part pops it,
// which leaves the back part idle; a query is walked by the back part, which lifts the deeper
// node to the depth of the other and then steps both nodes until they meet, unless one is an
// ancestor; an out-of-range query skips the walk. One query at a time is in the walk unit, one
// parent step per cycle while walking, set by the registered read of the node table memory.
// Reset clears control state and sets node_count to 1; tables are undefined until loaded.
// ----------------------------------------------------------------------------
// tree_common_ancestor_query
// Nearest common ancestor in a host-loaded rooted tree (parent/depth tables).
// ----------------------------------------------------------------------------
`default_nettype none

`include "tree_common_ancestor_query_assert.svh"

module tree_common_ancestor_query #(
	parameter int MAX_NODES = tcaq_pkg::DEF_MAX_NODES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [tcaq_pkg::CNT_W-1:0]    cfg_wdata,
	// input items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          func,
	input  wire logic [tcaq_pkg::NODE_W-1:0]   entry_node,
	input  wire logic [tcaq_pkg::NODE_W-1:0]   entry_parent,
	input  wire logic [tcaq_pkg::NODE_W-1:0]   entry_depth,
	input  wire logic [tcaq_pkg::NODE_W-1:0]   query_x,
	input  wire logic [tcaq_pkg::NODE_W-1:0]   query_y,
	// result items
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tcaq_pkg::NODE_W-1:0]        ancestor,
	output logic [tcaq_pkg::STATUS_W-1:0]      status
);
	import tcaq_pkg::*;

	// Largest count the tables hold, clipped to what the register can show
	localparam int CAP = (MAX_NODES < (1 << CNT_W)) ? MAX_NODES : ((1 << CNT_W) - 1);
	localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAP);

	logic [CNT_W-1:0] node_count_q;
	logic [CNT_W-1:0] lim;
	qhead_t           head;
	logic             pop;

	// Node count register; the user must write it only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Effective count: the smaller of the register and the table size
	assign lim = (node_count_q < CAP_W) ? node_count_q : CAP_W;

	// Front: classify loads and queries, range-check query nodes, hold in queue
	tcaq_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.entry_node   (entry_node),
		.entry_parent (entry_parent),
		.entry_depth  (entry_depth),
		.query_x      (query_x),
		.query_y      (query_y),
		.lim          (lim),
		.head         (head),
		.pop          (pop)
	);

	// Back: write table entries, walk parent links, register the result
	tcaq_back #(
		.MAX_NODES (MAX_NODES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.lim       (lim),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ancestor  (ancestor),
		.status    (status)
	);

	// A full queue always shows an item to the back part
	`TCAQ_ASSERT_NOW(a_full_has_head, clk, arst_n, !in_ready, head.valid)
	// The back part pops only an item that is there
	`TCAQ_ASSERT_NOW(a_pop_valid, clk, arst_n, pop, head.valid)
	// Only a found result carries an ancestor
	`TCAQ_ASSERT_NOW(a_anc_zero, clk, arst_n, out_valid && (status != STATUS_FOUND), ancestor == '0)
	// A found ancestor lies inside the table
	`TCAQ_ASSERT_NOW(a_anc_in_table, clk, arst_n, out_valid && (status == STATUS_FOUND), {1'b0, ancestor} < lim)

endmodule

`default_nettype wire

// ----- design/tcaq_front.sv -----
// ----------------------------------------------------------------------------
// tcaq_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcaq_front #(
	parameter int MAX_NODES = tcaq_pkg::DEF_MAX_NODES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        func,
	input  wire logic [tcaq_pkg::NODE_W-1:0] entry_node,
	input  wire logic [tcaq_pkg::NODE_W-1:0] entry_parent,
	input  wire logic [tcaq_pkg::NODE_W-1:0] entry_depth,
	input  wire logic [tcaq_pkg::NODE_W-1:0] query_x,
	input  wire logic [tcaq_pkg::NODE_W-1:0] query_y,
	input  wire logic [tcaq_pkg::CNT_W-1:0]  lim,
	output tcaq_pkg::qhead_t                 head,
	input  wire logic                        pop
);
	import tcaq_pkg::*;

	localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
	localparam logic [NODE_W:0] DEPTH_W = (NODE_W + 1)'(DEPTH);

	qitem_t     cls_item;
	qitem_t     buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;

	// Classify the incoming item
	always_comb begin
		cls_item.a = entry_node;
		cls_item.b = entry_parent;
		cls_item.c = entry_depth;
		if (func == FUNC_LOAD) begin
			cls_item.kind = ({1'b0, entry_node} < DEPTH_W) ? KIND_LOAD : KIND_DROP;
		end else begin
			cls_item.a    = query_x;
			cls_item.b    = query_y;
			cls_item.c    = '0;
			cls_item.kind = (({1'b0, query_x} >= lim) || ({1'b0, query_y} >= lim)) ?
				KIND_REJECT : KIND_QUERY;
		end
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign do_pop     = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cls_item;
		end
	end

endmodule

`default_nettype wire

// ----- design/tcaq_back.sv -----
// ----------------------------------------------------------------------------
// tcaq_back
// Holds the node tables and walks parent links to answer queries.
// ----------------------------------------------------------------------------
`default_nettype none

module tcaq_back #(
	parameter int MAX_NODES = tcaq_pkg::DEF_MAX_NODES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  tcaq_pkg::qhead_t                   head,
	output logic                               pop,
	input  wire logic [tcaq_pkg::CNT_W-1:0]    lim,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tcaq_pkg::NODE_W-1:0]        ancestor,
	output logic [tcaq_pkg::STATUS_W-1:0]      status
);
	import tcaq_pkg::*;

	localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_NODES + 1);
	localparam logic [SW-1:0] STEP_LIMIT = SW'(MAX_NODES);

	entry_t            mem [DEPTH];
	entry_t            rd_a_q;
	entry_t            rd_b_q;
	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [NODE_W-1:0] x_q, x_d;
	logic [NODE_W-1:0] y_q, y_d;
	logic [SW-1:0]     steps_q, steps_d;
	status_t           res_st_q, res_st_d;
	logic [NODE_W-1:0] res_anc_q, res_anc_d;
	logic              wr_en;
	logic              out_load;
	logic              out_valid_q;
	logic [NODE_W-1:0] ancestor_q;
	status_t           status_q;
	logic              out_free;
	logic              steps_max;
	logic              pa_out, pb_out;
	logic              lift_x_go, lift_y_go, same;

	// Table memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head.item.a[AW-1:0]] <= '{parent: head.item.b, depth: head.item.c};
		end
		rd_a_q <= mem[x_d[AW-1:0]];
		rd_b_q <= mem[y_d[AW-1:0]];
	end

	// Walk conditions; the read data always matches x_q and y_q outside idle
	assign steps_max = (steps_q == STEP_LIMIT);
	assign pa_out    = ({1'b0, rd_a_q.parent} >= lim);
	assign pb_out    = ({1'b0, rd_b_q.parent} >= lim);
	assign lift_x_go = (rd_b_q.depth < rd_a_q.depth);
	assign lift_y_go = (rd_a_q.depth < rd_b_q.depth);
	assign same      = (x_q == y_q);
	assign out_free  = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					case (head.item.kind)
						KIND_QUERY:  state_d = BK_LIFT_X;
						KIND_REJECT: state_d = BK_DONE;
						default:     state_d = BK_IDLE;
					endcase
				end
			end
			BK_LIFT_X: begin
				if (lift_x_go) begin
					state_d = (steps_max || pa_out) ? BK_DONE : BK_LIFT_X;
				end else begin
					state_d = BK_LIFT_Y;
				end
			end
			BK_LIFT_Y: begin
				if (lift_y_go) begin
					state_d = (steps_max || pb_out) ? BK_DONE : BK_LIFT_Y;
				end else begin
					state_d = same ? BK_DONE : BK_MEET;
				end
			end
			BK_MEET: begin
				if (!same) begin
					state_d = (steps_max || pa_out || pb_out) ? BK_DONE : BK_MEET;
				end else begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Datapath and control outputs
	always_comb begin
		x_d       = x_q;
		y_d       = y_q;
		steps_d   = steps_q;
		res_st_d  = res_st_q;
		res_anc_d = res_anc_q;
		pop       = 1'b0;
		wr_en     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop = head.valid;
				if (head.valid) begin
					case (head.item.kind)
						KIND_LOAD: wr_en = 1'b1;
						KIND_QUERY: begin
							x_d     = head.item.a;
							y_d     = head.item.b;
							steps_d = '0;
						end
						KIND_REJECT: begin
							res_st_d  = STATUS_NOT_IN_TABLE;
							res_anc_d = '0;
						end
						default: ;
					endcase
				end
			end
			BK_LIFT_X: begin
				if (lift_x_go) begin
					if (steps_max || pa_out) begin
						res_st_d  = STATUS_NOT_IN_TABLE;
						res_anc_d = '0;
					end else begin
						x_d     = rd_a_q.parent;
						steps_d = steps_q + 1'b1;
					end
				end else begin
					steps_d = '0;
				end
			end
			BK_LIFT_Y: begin
				if (lift_y_go) begin
					if (steps_max || pb_out) begin
						res_st_d  = STATUS_NOT_IN_TABLE;
						res_anc_d = '0;
					end else begin
						y_d     = rd_b_q.parent;
						steps_d = steps_q + 1'b1;
					end
				end else if (same) begin
					res_st_d  = STATUS_ANCESTOR;
					res_anc_d = '0;
				end else begin
					steps_d = '0;
				end
			end
			BK_MEET: begin
				if (!same) begin
					if (steps_max || pa_out || pb_out) begin
						res_st_d  = STATUS_NOT_IN_TABLE;
						res_anc_d = '0;
					end else begin
						x_d     = rd_a_q.parent;
						y_d     = rd_b_q.parent;
						steps_d = steps_q + 1'b1;
					end
				end else begin
					res_st_d  = STATUS_FOUND;
					res_anc_d = x_q;
				end
			end
			BK_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q       <= x_d;
		y_q       <= y_d;
		steps_q   <= steps_d;
		res_st_q  <= res_st_d;
		res_anc_q <= res_anc_d;
		if (out_load) begin
			ancestor_q <= res_anc_q;
			status_q   <= res_st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ancestor  = ancestor_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ----- tb/tree_common_ancestor_query_test.sv -----
// ----------------------------------------------------------------------------
// tree_common_ancestor_query_test
// Self-checking bench for the common ancestor query block. A planner builds
// small random trees and vets each query so that every walk reads only loaded
// entries. A driver and a monitor move the items under random stalls. Every
// accepted query is predicted from a shadow copy of the parent and depth
// tables, and every result is compared with that prediction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_common_ancestor_query_test;
	import tcaq_pkg::*;

	localparam int MAX_NODES  = DEF_MAX_NODES;
	localparam bit PLAN       = 1'b0;  // tables as the planner has queued them
	localparam bit LIVE       = 1'b1;  // tables as of the last accepted item
	localparam int SHORT_WALK = 40;    // parent steps allowed without a budget
	localparam int LOAD_TAIL  = 40;    // cycles for queued loads to retire
	localparam int IDLE_PCT   = 13;

	typedef struct packed {
		logic              func;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] parent;
		logic [NODE_W-1:0] depth;
		logic [NODE_W-1:0] qx;
		logic [NODE_W-1:0] qy;
	} tree_req_t;

	typedef struct packed {
		logic [NODE_W-1:0] anc;
		status_t           st;
	} tree_ans_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata    = '0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic              func         = FUNC_LOAD;
	logic [NODE_W-1:0] entry_node   = '0;
	logic [NODE_W-1:0] entry_parent = '0;
	logic [NODE_W-1:0] entry_depth  = '0;
	logic [NODE_W-1:0] query_x      = '0;
	logic [NODE_W-1:0] query_y      = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [NODE_W-1:0] ancestor;
	logic [STATUS_W-1:0] status;

	// Shadow tables: one side for the planner, one side kept in step with the block
	logic [NODE_W-1:0] parent_of [0:1][0:MAX_NODES-1];
	logic [NODE_W-1:0] depth_of  [0:1][0:MAX_NODES-1];
	bit                loaded    [0:1][0:MAX_NODES-1];
	int unsigned       node_limit;

	tree_req_t   queued_reqs[$];  // items waiting for the driver
	tree_ans_t   awaited[$];      // predicted results, oldest first
	int          errors = 0;
	int          long_walks_left = 0;
	bit          steady = 1'b0;   // suppress all idling on both sides
	bit          in_taken = 1'b0; // the item on the input port went in

	tree_common_ancestor_query i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.entry_node   (entry_node),
		.entry_parent (entry_parent),
		.entry_depth  (entry_depth),
		.query_x      (query_x),
		.query_y      (query_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ancestor     (ancestor),
		.status       (status)
	);

	always #5 clk = ~clk;

	// Node count as the block uses it: capped at the table size
	function automatic int table_span();
		return (node_limit < MAX_NODES) ? int'(node_limit) : MAX_NODES;
	endfunction

	// Walk one query over the chosen side of the tables. Flag a read of an
	// entry never loaded, and count the parent steps taken.
	function automatic void nearest_common(input bit side,
		input logic [NODE_W-1:0] qx, input logic [NODE_W-1:0] qy,
		output tree_ans_t ans, output bit blind, output int walk_len);
		int lim;
		int n;
		logic [NODE_W-1:0] x;
		logic [NODE_W-1:0] y;
		lim = table_span();
		x = qx;
		y = qy;
		ans.anc = '0;
		ans.st = STATUS_NOT_IN_TABLE;
		blind = 1'b0;
		walk_len = 0;
		if (x >= lim || y >= lim)
			return;
		blind = !loaded[side][x] || !loaded[side][y];
		// lift the deeper node until the depths agree
		for (n = 0; depth_of[side][y] < depth_of[side][x]; n++) begin
			if (n >= MAX_NODES)
				return;
			x = parent_of[side][x];
			walk_len++;
			if (x >= lim)
				return;
			blind |= !loaded[side][x];
		end
		for (n = 0; depth_of[side][x] < depth_of[side][y]; n++) begin
			if (n >= MAX_NODES)
				return;
			y = parent_of[side][y];
			walk_len++;
			if (y >= lim)
				return;
			blind |= !loaded[side][y];
		end
		if (x == y) begin
			ans.st = STATUS_ANCESTOR;
			return;
		end
		// climb both together until they meet
		for (n = 0; x != y; n++) begin
			if (n >= MAX_NODES)
				return;
			blind |= !loaded[side][x] || !loaded[side][y];
			x = parent_of[side][x];
			y = parent_of[side][y];
			walk_len++;
			if (x >= lim || y >= lim)
				return;
		end
		ans.anc = x;
		ans.st = STATUS_FOUND;
	endfunction

	function automatic bit take_break();
		return !steady && $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	function automatic void note_fault(input string what);
		errors++;
		if (errors <= 10)
			$display("mismatch at %0t: %s", $time, what);
	endfunction

	function automatic logic [NODE_W-1:0] pick_node();
		int lim;
		lim = table_span();
		if (lim > 0 && $urandom_range(0, 9) != 0)
			return NODE_W'($urandom_range(0, lim - 1));
		return NODE_W'($urandom_range(0, MAX_NODES - 1));
	endfunction

	// Queue a load and apply it to the planner's tables right away
	task automatic plan_load(input logic [NODE_W-1:0] node,
		input logic [NODE_W-1:0] parent, input logic [NODE_W-1:0] depth);
		tree_req_t r;
		r.func = FUNC_LOAD;
		r.node = node;
		r.parent = parent;
		r.depth = depth;
		r.qx = NODE_W'($urandom_range(0, MAX_NODES - 1));
		r.qy = NODE_W'($urandom_range(0, MAX_NODES - 1));
		parent_of[PLAN][node] = parent;
		depth_of[PLAN][node] = depth;
		loaded[PLAN][node] = 1'b1;
		queued_reqs = {queued_reqs, r};
	endtask

	task automatic plan_query(input logic [NODE_W-1:0] x, input logic [NODE_W-1:0] y);
		tree_req_t r;
		r.func = FUNC_QUERY;
		r.node = NODE_W'($urandom_range(0, MAX_NODES - 1));
		r.parent = NODE_W'($urandom_range(0, MAX_NODES - 1));
		r.depth = NODE_W'($urandom_range(0, MAX_NODES - 1));
		r.qx = x;
		r.qy = y;
		queued_reqs = {queued_reqs, r};
	endtask

	// Drop a query that would read an unloaded entry; allow only a few long walks
	task automatic try_query(input logic [NODE_W-1:0] x, input logic [NODE_W-1:0] y,
		inout int made);
		tree_ans_t ans;
		bit blind;
		int walk_len;
		nearest_common(PLAN, x, y, ans, blind, walk_len);
		if (blind)
			return;
		if (walk_len > SHORT_WALK) begin
			if (long_walks_left == 0)
				return;
			long_walks_left--;
		end
		plan_query(x, y);
		made++;
	endtask

	// Write node_count; only called with the block idle
	task automatic set_node_count(input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[CNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		node_limit = 32'(value[CNT_W-1:0]);
	endtask

	// Hold until every item went in and every result came back, then let
	// trailing loads retire
	task automatic settle();
		while (queued_reqs.size() != 0 || in_valid || awaited.size() != 0)
			@(posedge clk);
		repeat (LOAD_TAIL) @(posedge clk);
	endtask

	// Mostly small well-formed trees followed by queries over their nodes;
	// the rest is random loads and random or out-of-range queries.
	task automatic random_phase(input int unsigned count, input int items, input bit calm);
		int made;
		int roll;
		int k;
		logic [NODE_W-1:0] built[$];
		logic [NODE_W-1:0] p;
		logic [NODE_W-1:0] n;
		logic [NODE_W-1:0] x;
		logic [NODE_W-1:0] y;
		set_node_count(count);
		steady = calm;
		long_walks_left = 2;
		made = 0;
		while (made < items) begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				k = $urandom_range(2, 12);
				built.delete();
				n = pick_node();
				plan_load(n, NODE_W'($urandom_range(0, MAX_NODES - 1)), '0);
				built = {built, n};
				made++;
				repeat (k - 1) begin
					p = built[$urandom_range(0, built.size() - 1)];
					n = pick_node();
					plan_load(n, p, depth_of[PLAN][p] + 1'b1);
					built = {built, n};
					made++;
				end
				repeat ($urandom_range(2, 8)) begin
					x = built[$urandom_range(0, built.size() - 1)];
					y = ($urandom_range(0, 7) == 0) ? pick_node()
						: built[$urandom_range(0, built.size() - 1)];
					try_query(x, y, made);
				end
			end else if (roll < 85) begin
				plan_load(NODE_W'($urandom_range(0, MAX_NODES - 1)),
					NODE_W'($urandom_range(0, MAX_NODES - 1)),
					NODE_W'($urandom_range(0, MAX_NODES - 1)));
				made++;
			end else if (roll < 95) begin
				try_query(NODE_W'($urandom_range(0, MAX_NODES - 1)),
					NODE_W'($urandom_range(0, MAX_NODES - 1)), made);
			end else begin
				// aim at a node past the end of the table where there is room
				y = NODE_W'($urandom_range(table_span() < MAX_NODES ? table_span() : 0,
					MAX_NODES - 1));
				if ($urandom_range(0, 1))
					try_query(pick_node(), y, made);
				else
					try_query(y, pick_node(), made);
			end
		end
		settle();
		steady = 1'b0;
	endtask

	// Driver: advance the input item only once the current one went in,
	// and stall the result side at random
	always @(negedge clk) begin
		tree_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (queued_reqs.size() != 0 && !take_break()) begin
					r = queued_reqs.pop_front();
					func <= r.func;
					entry_node <= r.node;
					entry_parent <= r.parent;
					entry_depth <= r.depth;
					query_x <= r.qx;
					query_y <= r.qy;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !take_break();
		end
	end

	// Monitor: update the live tables or predict on each accepted item,
	// then check each accepted result against the oldest prediction
	always @(posedge clk) begin : monitor
		tree_ans_t ans;
		tree_ans_t want;
		bit blind;
		int walk_len;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				if (func == FUNC_LOAD) begin
					if (entry_node < MAX_NODES) begin
						parent_of[LIVE][entry_node] = entry_parent;
						depth_of[LIVE][entry_node] = entry_depth;
						loaded[LIVE][entry_node] = 1'b1;
					end
				end else begin
					nearest_common(LIVE, query_x, query_y, ans, blind, walk_len);
					awaited = {awaited, ans};
				end
			end
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					note_fault($sformatf("result ancestor %0d status %0d with none expected",
						ancestor, status));
				end else begin
					want = awaited.pop_front();
					if (ancestor !== want.anc || status !== want.st)
						note_fault($sformatf("expected ancestor %0d status %0d, got %0d %0d",
							want.anc, want.st, ancestor, status));
				end
			end
		end
	end

	initial begin
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				parent_of[s][i] = '0;
				depth_of[s][i] = '0;
				loaded[s][i] = 1'b0;
			end
		end
		node_limit = 32'(NODE_COUNT_RESET);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset count of one: only node 0 is in the table
		plan_load(10'd0, 10'd1023, 10'd0);
		plan_query(10'd0, 10'd0);         // same node
		plan_query(10'd0, 10'd1);         // second node out of range
		plan_query(10'd1023, 10'd1023);
		settle();

		// Full table: a small tree spread over both ends of the index range
		set_node_count(MAX_NODES);
		plan_load(10'd1023, 10'd0, 10'd1);
		plan_load(10'd5, 10'd0, 10'd1);
		plan_load(10'd682, 10'd5, 10'd2);
		plan_load(10'd341, 10'd1023, 10'd2);
		plan_load(10'd7, 10'd1023, 10'd1);
		plan_load(10'd100, 10'd0, 10'd1023);   // deepest depth value
		plan_load(10'd200, 10'd200, 10'd1023); // self loop: lift never ends
		plan_load(10'd201, 10'd201, 10'd1023); // second self loop: never meet
		plan_load(10'd900, 10'd5, 10'd2);
		plan_query(10'd682, 10'd341);     // meet at the root
		plan_query(10'd682, 10'd5);       // y is an ancestor of x
		plan_query(10'd5, 10'd682);       // x is an ancestor of y
		plan_query(10'd682, 10'd1023);    // lift, then meet
		plan_query(10'd100, 10'd0);
		plan_query(10'd200, 10'd5);       // lift runs out of steps
		plan_query(10'd200, 10'd201);     // meet runs out of steps
		settle();

		// Smaller count: walk leaves the table, and a node loaded past the count
		set_node_count(300);
		plan_query(10'd7, 10'd0);
		plan_query(10'd900, 10'd0);
		settle();

		set_node_count(0);
		plan_query(10'd0, 10'd0);
		settle();

		// Largest register value caps at the table size
		set_node_count(2047);
		plan_query(10'd900, 10'd682);
		plan_query(10'd0, 10'd1023);
		settle();

		random_phase(MAX_NODES, 250, 1'b1);
		random_phase($urandom_range(64, 1023), 200, 1'b0);
		random_phase(2047, 200, 1'b0);
		random_phase($urandom_range(2, 20), 120, 1'b0);
		random_phase(0, 30, 1'b0);
		random_phase(MAX_NODES, 150, 1'b0);

		errors += awaited.size();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/tcaq_pkg.sv
design/tcaq_front.sv
design/tcaq_back.sv
design/tree_common_ancestor_query.sv
tb/tree_common_ancestor_query_test.sv
